@@ sv/voxel_cube_draw_engine_macros.svh @@
// Assertion macros used by the engine's controller RTL.
`ifndef VOXEL_CUBE_DRAW_ENGINE_MACROS_SVH
`define VOXEL_CUBE_DRAW_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property, checking held off during reset.
`define VCDE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true.
`define VCDE_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VCDE_ASSERT(label, clk, rst_n, prop, msg)
`define VCDE_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/vcde_pkg.sv @@
// Shared types and codes of the voxel cube draw engine.
package vcde_pkg;

	localparam int ROW_W  = 8;
	localparam int ROWS   = 64;
	localparam int ADDR_W = 6;

	typedef enum logic [3:0] {
		FN_SET    = 4'd0,
		FN_CLR    = 4'd1,
		FN_FLIP   = 4'd2,
		FN_READ   = 4'd3,
		FN_WRITE  = 4'd4,
		FN_PSET   = 4'd5,
		FN_PCLR   = 4'd6,
		FN_FILL   = 4'd7,
		FN_BOXF   = 4'd8,
		FN_BOXW   = 4'd9,
		FN_BOXE   = 4'd10,
		FN_SHIFT  = 4'd11,
		FN_MIRX   = 4'd12,
		FN_MIRY   = 4'd13,
		FN_MIRZ   = 4'd14
	} func_t;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;
	localparam logic [1:0] AX_BAD = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic cnt_clear;
		logic cnt_step;
		logic we;
		logic wsel_b;
		logic vox_cap;
		logic res_load;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic ign;
		logic last;
		logic swap;
	} stat_t;

endpackage

@@ sv/vcde_if.sv @@
// Command and response channel interfaces.
interface vcde_cmd_if;
	logic              valid;
	logic              ready;
	logic [3:0]        func;
	logic signed [4:0] x1;
	logic signed [4:0] y1;
	logic signed [4:0] z1;
	logic signed [4:0] x2;
	logic signed [4:0] y2;
	logic signed [4:0] z2;
	logic [1:0]        axis;
	logic signed [4:0] position;
	logic              direction;
	logic [7:0]        pattern;
	logic              bit_value;

	modport source (output valid, func, x1, y1, z1, x2, y2, z2, axis, position,
		direction, pattern, bit_value, input ready);
	modport sink (input valid, func, x1, y1, z1, x2, y2, z2, axis, position,
		direction, pattern, bit_value, output ready);
endinterface

interface vcde_rsp_if;
	logic valid;
	logic ready;
	logic voxel;
	logic ignored;

	modport source (output valid, voxel, ignored, input ready);
	modport sink (input valid, voxel, ignored, output ready);
endinterface

@@ sv/voxel_cube_draw_engine.sv @@
// Top level of the voxel cube draw engine.
// Frame buffer of 64 rows of 8 voxels (row = z*8+y, bit = x), cleared at reset
// through per-row valid bits, so no clearing pass is needed and the block is ready
// right after reset. One command is in work at a time; the next is accepted as soon
// as the engine returns to idle, while the previous result may still wait in the
// response register. The work is a walk over the row memory, a read and a write per
// row: voxel commands touch one row, bad operands skip the walk, whole-cube commands
// (plane, fill, box, shift, mirror x) walk all 64 rows, and mirror y/z walk 32 row
// pairs, since each row pair is read once and written twice.
module voxel_cube_draw_engine (
	input  logic       clk,
	input  logic       arst_n,
	vcde_cmd_if.sink   cmd,
	vcde_rsp_if.source rsp
);

	vcde_pkg::ctl_t  ctl;
	vcde_pkg::stat_t stat;

	vcde_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.ctl     (ctl),
		.stat    (stat),
		.voxel   (rsp.voxel),
		.ignored (rsp.ignored)
	);

	vcde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

endmodule

@@ sv/vcde_datapath.sv @@
// Datapath: command registers, row memory, address sequencing and row update.
module vcde_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	vcde_cmd_if.sink             cmd,
	input  vcde_pkg::ctl_t       ctl,
	output vcde_pkg::stat_t      stat,
	output logic                 voxel,
	output logic                 ignored
);

	vcde_pkg::func_t   func_q;
	logic signed [4:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, pos_q;
	logic [1:0]        axis_q;
	logic              dir_q;
	logic [7:0]        pat_q;
	logic              bv_q;

	logic [vcde_pkg::ROW_W-1:0]  mem [vcde_pkg::ROWS];
	logic [vcde_pkg::ROWS-1:0]   valid_q;
	logic [vcde_pkg::ROW_W-1:0]  rda_q, rdb_q;
	logic [vcde_pkg::ADDR_W-1:0] idx_q;
	logic                        vox_q, voxel_q, ignored_q;

	logic in1, in2;
	logic ign_c, last_c, swap_c;
	logic [2:0] xa, xb, ya, yb, za, zb, cy, cz;
	logic [7:0] line, ends, m, pbit, wrow, wdata;
	logic [5:0] ra, rb, waddr;
	logic       src_oob, in_y, in_z, y_edge, z_edge;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[i] = v[7-i];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			func_q <= vcde_pkg::func_t'(cmd.func);
			x1_q   <= cmd.x1;
			y1_q   <= cmd.y1;
			z1_q   <= cmd.z1;
			x2_q   <= cmd.x2;
			y2_q   <= cmd.y2;
			z2_q   <= cmd.z2;
			axis_q <= cmd.axis;
			pos_q  <= cmd.position;
			dir_q  <= cmd.direction;
			pat_q  <= cmd.pattern;
			bv_q   <= cmd.bit_value;
		end
	end

	// inside the cube: sign and bit 3 both clear
	assign in1 = (x1_q[4:3] == 2'b00) && (y1_q[4:3] == 2'b00) && (z1_q[4:3] == 2'b00);
	assign in2 = (x2_q[4:3] == 2'b00) && (y2_q[4:3] == 2'b00) && (z2_q[4:3] == 2'b00);

	always_comb begin
		case (func_q)
			vcde_pkg::FN_SET, vcde_pkg::FN_CLR, vcde_pkg::FN_FLIP,
			vcde_pkg::FN_READ, vcde_pkg::FN_WRITE:
				ign_c = !in1;
			vcde_pkg::FN_PSET, vcde_pkg::FN_PCLR:
				ign_c = (axis_q == vcde_pkg::AX_BAD) || (pos_q[4:3] != 2'b00);
			vcde_pkg::FN_BOXF, vcde_pkg::FN_BOXW, vcde_pkg::FN_BOXE:
				ign_c = !(in1 && in2);
			vcde_pkg::FN_SHIFT:
				ign_c = (axis_q == vcde_pkg::AX_BAD);
			vcde_pkg::FN_FILL, vcde_pkg::FN_MIRX, vcde_pkg::FN_MIRY, vcde_pkg::FN_MIRZ:
				ign_c = 1'b0;
			default:
				ign_c = 1'b1;
		endcase
	end

	assign swap_c = (func_q == vcde_pkg::FN_MIRY) || (func_q == vcde_pkg::FN_MIRZ);

	always_comb begin
		if (func_q <= vcde_pkg::FN_WRITE) last_c = 1'b1;
		else if (swap_c)                  last_c = (idx_q == 6'd31);
		else                              last_c = (idx_q == 6'd63);
	end

	assign stat = '{ign: ign_c, last: last_c, swap: swap_c};

	// sorted box corners
	assign xa = (x1_q[2:0] < x2_q[2:0]) ? x1_q[2:0] : x2_q[2:0];
	assign xb = (x1_q[2:0] < x2_q[2:0]) ? x2_q[2:0] : x1_q[2:0];
	assign ya = (y1_q[2:0] < y2_q[2:0]) ? y1_q[2:0] : y2_q[2:0];
	assign yb = (y1_q[2:0] < y2_q[2:0]) ? y2_q[2:0] : y1_q[2:0];
	assign za = (z1_q[2:0] < z2_q[2:0]) ? z1_q[2:0] : z2_q[2:0];
	assign zb = (z1_q[2:0] < z2_q[2:0]) ? z2_q[2:0] : z1_q[2:0];

	assign line = (8'hff << xa) & (8'hff >> (3'd7 - xb));
	assign ends = (8'd1 << xa) | (8'd1 << xb);
	assign m    = 8'd1 << x1_q[2:0];
	assign pbit = 8'd1 << pos_q[2:0];

	// row addresses: a = destination, b = source or mirror partner
	always_comb begin
		ra = idx_q;
		rb = idx_q;
		if (func_q <= vcde_pkg::FN_WRITE) begin
			ra = {z1_q[2:0], y1_q[2:0]};
			rb = ra;
		end else if (func_q == vcde_pkg::FN_MIRY) begin
			ra = {idx_q[4:2], 1'b0, idx_q[1:0]};
			rb = {idx_q[4:2], 1'b1, ~idx_q[1:0]};
		end else if (func_q == vcde_pkg::FN_MIRZ) begin
			ra = {1'b0, idx_q[4:3], idx_q[2:0]};
			rb = {1'b1, ~idx_q[4:3], idx_q[2:0]};
		end else if (func_q == vcde_pkg::FN_SHIFT) begin
			// toward higher index walks rows downward so sources are still old
			ra = dir_q ? ~idx_q : idx_q;
			if (axis_q == vcde_pkg::AX_Y)
				rb = {ra[5:3], dir_q ? ra[2:0] - 3'd1 : ra[2:0] + 3'd1};
			else
				rb = {dir_q ? ra[5:3] - 3'd1 : ra[5:3] + 3'd1, ra[2:0]};
		end
	end

	assign cy = ra[2:0];
	assign cz = ra[5:3];
	always_comb begin
		if (axis_q == vcde_pkg::AX_Y) src_oob = dir_q ? (cy == 3'd0) : (cy == 3'd7);
		else                          src_oob = dir_q ? (cz == 3'd0) : (cz == 3'd7);
	end
	assign in_y   = (cy >= ya) && (cy <= yb);
	assign in_z   = (cz >= za) && (cz <= zb);
	assign y_edge = (cy == ya) || (cy == yb);
	assign z_edge = (cz == za) || (cz == zb);

	always_comb begin
		case (func_q)
			vcde_pkg::FN_SET:   wrow = rda_q | m;
			vcde_pkg::FN_CLR:   wrow = rda_q & ~m;
			vcde_pkg::FN_FLIP:  wrow = rda_q ^ m;
			vcde_pkg::FN_READ:  wrow = rda_q;
			vcde_pkg::FN_WRITE: wrow = bv_q ? (rda_q | m) : (rda_q & ~m);
			vcde_pkg::FN_PSET, vcde_pkg::FN_PCLR: begin
				if (axis_q == vcde_pkg::AX_X)
					wrow = (func_q == vcde_pkg::FN_PSET) ? (rda_q | pbit) : (rda_q & ~pbit);
				else if ((axis_q == vcde_pkg::AX_Y && cy == pos_q[2:0]) ||
					(axis_q == vcde_pkg::AX_Z && cz == pos_q[2:0]))
					wrow = (func_q == vcde_pkg::FN_PSET) ? 8'hff : 8'h00;
				else
					wrow = rda_q;
			end
			vcde_pkg::FN_FILL:  wrow = pat_q;
			vcde_pkg::FN_BOXF:  wrow = (in_y && in_z) ? (rda_q | line) : rda_q;
			vcde_pkg::FN_BOXW: begin
				if (!(in_y && in_z))     wrow = rda_q;
				else if (y_edge || z_edge) wrow = line;
				else                     wrow = rda_q | ends;
			end
			vcde_pkg::FN_BOXE: begin
				if (y_edge && z_edge)
					wrow = line;
				else if ((in_y && z_edge) || (in_z && y_edge))
					wrow = rda_q | ends;
				else
					wrow = rda_q;
			end
			vcde_pkg::FN_SHIFT: begin
				if (axis_q == vcde_pkg::AX_X) wrow = dir_q ? (rda_q << 1) : (rda_q >> 1);
				else                          wrow = src_oob ? 8'h00 : rdb_q;
			end
			vcde_pkg::FN_MIRX:  wrow = rev8(rda_q);
			vcde_pkg::FN_MIRY, vcde_pkg::FN_MIRZ: wrow = rdb_q;
			default:            wrow = rda_q;
		endcase
	end

	assign wdata = ctl.wsel_b ? rda_q : wrow;
	assign waddr = ctl.wsel_b ? rb : ra;

	// unwritten rows read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) mem[waddr] <= wdata;
		rda_q <= valid_q[ra] ? mem[ra] : 8'h00;
		rdb_q <= valid_q[rb] ? mem[rb] : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (ctl.cnt_clear)     idx_q <= '0;
		else if (ctl.cnt_step) idx_q <= idx_q + 6'd1;
		if (ctl.load)          vox_q <= 1'b0;
		else if (ctl.vox_cap)  vox_q <= (func_q == vcde_pkg::FN_READ) && rda_q[x1_q[2:0]];
		if (ctl.res_load) begin
			voxel_q   <= vox_q;
			ignored_q <= ign_c;
		end
	end

	assign voxel   = voxel_q;
	assign ignored = ignored_q;

endmodule

@@ sv/vcde_ctrl.sv @@
// Controller: command sequencing over the row memory and result handoff.
`include "voxel_cube_draw_engine_macros.svh"
module vcde_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  vcde_pkg::stat_t stat,
	output vcde_pkg::ctl_t  ctl
);

	typedef enum logic [2:0] {S_IDLE, S_CHK, S_RD, S_WR, S_WB, S_DONE} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: ctl.load = in_valid;
			S_CHK:  ctl.cnt_clear = 1'b1;
			S_RD:   ;
			S_WR: begin
				ctl.we       = 1'b1;
				ctl.vox_cap  = 1'b1;
				ctl.cnt_step = !stat.swap && !stat.last;
			end
			S_WB: begin
				ctl.we       = 1'b1;
				ctl.wsel_b   = 1'b1;
				ctl.cnt_step = !stat.last;
			end
			S_DONE: ctl.res_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (state_q == S_DONE && slot_free) out_valid_q <= 1'b1;
			else if (out_ready)                 out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CHK;
				S_CHK:  state_q <= stat.ign ? S_DONE : S_RD;
				S_RD:   state_q <= S_WR;
				S_WR: begin
					if (stat.swap)      state_q <= S_WB;
					else if (stat.last) state_q <= S_DONE;
					else                state_q <= S_RD;
				end
				S_WB:   state_q <= stat.last ? S_DONE : S_RD;
				S_DONE: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`VCDE_ASSERT(a_we_phase, clk, arst_n, ctl.we |-> (state_q == S_WR || state_q == S_WB), "write outside write phase")
	`VCDE_ASSERT(a_accept, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_CHK), "accepted command not checked")
	`VCDE_NEVER(a_overrun, clk, arst_n, ctl.res_load && out_valid_q && !out_ready, "result overwritten")
	`VCDE_ASSERT(a_wb_after_wr, clk, arst_n, (state_q == S_WB) |-> ($past(state_q) == S_WR), "second write without first")

endmodule
